[sv/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_PROTO = 2'd1;
	localparam logic [1:0] ERR_TEXT  = 2'd2;
	localparam logic [1:0] ERR_BIG   = 2'd3;

	localparam logic [3:0] OPC_CONT     = 4'd0;
	localparam logic [3:0] OPC_TEXT     = 4'd1;
	localparam logic [3:0] OPC_BIN      = 4'd2;
	localparam logic [3:0] OPC_RSV_LO   = 4'd3;
	localparam logic [3:0] OPC_RSV_HI   = 4'd7;
	localparam logic [3:0] OPC_CTRL_MIN = 4'd8;
	localparam logic [3:0] OPC_CTRL_MAX = 4'd10;

	localparam logic [3:0] OPC_MASK  = 4'h0F;
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;
	localparam logic [3:0] BASE_HDR    = 4'd2;

	localparam logic [31:0] MAX_FRAME_LEN_RST = 32'd65536;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic [3:0] frame_opcode;
		logic       has_data;
		logic       msg_end;
		logic [1:0] error_code;
	} result_t;

endpackage

[sv/wsd_if.sv]
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// valid/ready channels of the deframer: received bytes in, results out
// ----------------------------------------------------------------------------
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       has_data;
	logic       msg_end;
	logic [1:0] error_code;

	modport source (output valid, output payload_byte, output frame_opcode,
		output has_data, output msg_end, output error_code, input ready);
	modport sink (input valid, input payload_byte, input frame_opcode,
		input has_data, input msg_end, input error_code, output ready);
endinterface

[sv/wsd_core.sv]
// ----------------------------------------------------------------------------
// wsd_core
// frame header and payload state machine, one byte per step
// ----------------------------------------------------------------------------
module wsd_core #(
	parameter int LENGTH_BITS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [31:0]         max_frame_len,
	output wsd_pkg::result_t    res,
	output logic                res_valid
);

	localparam int CW = (LENGTH_BITS > 33) ? LENGTH_BITS : 33;

	localparam logic [2:0] PH_HDR1  = 3'd0;
	localparam logic [2:0] PH_HDR2  = 3'd1;
	localparam logic [2:0] PH_EXT   = 3'd2;
	localparam logic [2:0] PH_KEY   = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_STUCK = 3'd5;

	logic [2:0]             phase_q, phase_d;
	logic                   fin_q, fin_d;
	logic                   mask_q, mask_d;
	logic [3:0]             opc_q, opc_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;
	logic [3:0]             cnt_q, cnt_d;
	logic [31:0]            key_q, key_d;
	logic [1:0]             idx_q, idx_d;
	logic                   frag_q, frag_d;
	logic [1:0]             err_q, err_d;
	logic [3:0]             hext_q, hext_d;

	logic [3:0]             opc_in;
	logic                   fin_in;
	logic [6:0]             len7;
	logic [LENGTH_BITS-1:0] rem_shift;
	logic [LENGTH_BITS-1:0] len_cand;
	logic                   mask_eff;
	logic [3:0]             hdr_len;
	logic [CW-1:0]          lim_w, hdr_w, rem_w;
	logic                   too_big;
	logic                   do_known;
	logic                   fail_en;
	logic [1:0]             fail_code;
	logic [7:0]             key_byte;
	logic                   last_byte;

	assign opc_in    = rx_byte[3:0] & wsd_pkg::OPC_MASK;
	assign fin_in    = rx_byte[7];
	assign len7      = rx_byte[6:0];
	assign rem_shift = {rem_q[LENGTH_BITS-9:0], rx_byte};
	assign len_cand  = (phase_q == PH_HDR2) ? LENGTH_BITS'(len7) : rem_shift;
	assign mask_eff  = (phase_q == PH_HDR2) ? rx_byte[7] : mask_q;
	assign hdr_len   = wsd_pkg::BASE_HDR + ((phase_q == PH_HDR2) ? 4'd0 : hext_q)
		+ (mask_eff ? wsd_pkg::KEY_BYTES : 4'd0);
	assign lim_w     = CW'(max_frame_len);
	assign hdr_w     = CW'(hdr_len);
	assign rem_w     = CW'(len_cand);
	assign too_big   = (lim_w < hdr_w) || (rem_w > (lim_w - hdr_w));
	assign key_byte  = key_q[8*(3-idx_q) +: 8];
	assign last_byte = (rem_q == LENGTH_BITS'(1));

	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		mask_d    = mask_q;
		opc_d     = opc_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		idx_d     = idx_q;
		frag_d    = frag_q;
		err_d     = err_q;
		hext_d    = hext_q;
		res       = '0;
		res_valid = 1'b0;
		do_known  = 1'b0;
		fail_en   = 1'b0;
		fail_code = wsd_pkg::ERR_NONE;

		case (phase_q)
			PH_HDR1: begin
				if (rx_byte[6:4] != 3'd0) begin
					fail_en   = 1'b1;
					fail_code = wsd_pkg::ERR_PROTO;
				end else if ((opc_in >= wsd_pkg::OPC_RSV_LO && opc_in <= wsd_pkg::OPC_RSV_HI)
						|| opc_in > wsd_pkg::OPC_CTRL_MAX) begin
					fail_en   = 1'b1;
					fail_code = wsd_pkg::ERR_PROTO;
				end else if (opc_in == wsd_pkg::OPC_TEXT) begin
					fail_en   = 1'b1;
					fail_code = wsd_pkg::ERR_TEXT;
				end else if (!fin_in && opc_in >= wsd_pkg::OPC_CTRL_MIN) begin
					fail_en   = 1'b1;
					fail_code = wsd_pkg::ERR_PROTO;
				end else if (fin_in && opc_in == wsd_pkg::OPC_BIN && frag_q) begin
					fail_en   = 1'b1;
					fail_code = wsd_pkg::ERR_PROTO;
				end else begin
					if (opc_in < wsd_pkg::OPC_CTRL_MIN) begin
						frag_d = !fin_in;
					end
					fin_d   = fin_in;
					opc_d   = opc_in;
					phase_d = PH_HDR2;
				end
			end
			PH_HDR2: begin
				mask_d = rx_byte[7];
				rem_d  = '0;
				if (len7 == wsd_pkg::LEN7_EXT16) begin
					hext_d  = wsd_pkg::EXT16_BYTES;
					cnt_d   = wsd_pkg::EXT16_BYTES;
					phase_d = PH_EXT;
				end else if (len7 == wsd_pkg::LEN7_EXT64) begin
					hext_d  = wsd_pkg::EXT64_BYTES;
					cnt_d   = wsd_pkg::EXT64_BYTES;
					phase_d = PH_EXT;
				end else begin
					hext_d   = 4'd0;
					rem_d    = len_cand;
					do_known = 1'b1;
				end
			end
			PH_EXT: begin
				if (rem_q[LENGTH_BITS-1 -: 8] != 8'd0) begin
					fail_en   = 1'b1;
					fail_code = wsd_pkg::ERR_BIG;
				end else begin
					rem_d = rem_shift;
					cnt_d = cnt_q - 4'd1;
					if (cnt_q == 4'd1) begin
						do_known = 1'b1;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], rx_byte};
				cnt_d = cnt_q - 4'd1;
				if (cnt_q == 4'd1) begin
					idx_d = 2'd0;
					if (rem_q == '0) begin
						phase_d = PH_HDR1;
						if (fin_q) begin
							res.frame_opcode = opc_q;
							res.msg_end      = 1'b1;
							res_valid        = 1'b1;
						end
					end else begin
						phase_d = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				idx_d = idx_q + 2'd1;
				rem_d = rem_q - LENGTH_BITS'(1);
				if (last_byte) begin
					phase_d = PH_HDR1;
				end
				res.payload_byte = mask_q ? (rx_byte ^ key_byte) : rx_byte;
				res.frame_opcode = opc_q;
				res.has_data     = 1'b1;
				res.msg_end      = last_byte && fin_q;
				res_valid        = 1'b1;
			end
			default: begin
				phase_d        = PH_STUCK;
				res.error_code = err_q;
				res_valid      = 1'b1;
			end
		endcase

		// header complete: size check, then key, empty frame or payload
		if (do_known) begin
			if (too_big) begin
				fail_en   = 1'b1;
				fail_code = wsd_pkg::ERR_BIG;
			end else if (mask_eff) begin
				phase_d = PH_KEY;
				cnt_d   = wsd_pkg::KEY_BYTES;
				key_d   = '0;
				idx_d   = 2'd0;
			end else if (len_cand == '0) begin
				phase_d = PH_HDR1;
				if (fin_q) begin
					res.frame_opcode = opc_q;
					res.msg_end      = 1'b1;
					res_valid        = 1'b1;
				end
			end else begin
				phase_d = PH_DATA;
			end
		end

		if (fail_en) begin
			err_d          = fail_code;
			phase_d        = PH_STUCK;
			res            = '0;
			res.error_code = fail_code;
			res_valid      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			fin_q   <= 1'b0;
			mask_q  <= 1'b0;
			opc_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			key_q   <= '0;
			idx_q   <= '0;
			frag_q  <= 1'b0;
			err_q   <= wsd_pkg::ERR_NONE;
			hext_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			fin_q   <= fin_d;
			mask_q  <= mask_d;
			opc_q   <= opc_d;
			rem_q   <= rem_d;
			cnt_q   <= cnt_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
			frag_q  <= frag_d;
			err_q   <= err_d;
			hext_q  <= hext_d;
		end
	end

endmodule

[sv/websocket_frame_deframer_unit.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// parses a received byte stream into unmasked, opcode-tagged payload items
//
//   channel  dir  carries
//   rx       in   rx_byte, one received byte per item
//   tx       out  payload_byte, frame_opcode, has_data, msg_end, error_code
//   cfg      in   max_frame_len write (cfg_wr_en, cfg_wr_data)
//
// one byte is taken every cycle that rx is ready; the header/payload
// state advances in the cycle a byte is taken and any result lands in
// the output register, which is refilled in the cycle it is taken, so rx
// only stalls while a result waits and tx is not ready
// reset returns to the first header byte and max_frame_len to 65536
// ----------------------------------------------------------------------------
module websocket_frame_deframer_unit #(
	parameter int LENGTH_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	wsd_in_if.sink      rx,
	wsd_out_if.source   tx,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	logic [31:0]      max_len_q;
	logic             out_valid_q;
	wsd_pkg::result_t out_q;
	wsd_pkg::result_t res;
	logic             res_valid;
	logic             step;
	logic             room;

	assign room     = !out_valid_q || tx.ready;
	assign rx.ready = room;
	assign step     = rx.valid && room;

	wsd_core #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.rx_byte(rx.rx_byte),
		.max_frame_len(max_len_q),
		.res(res),
		.res_valid(res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= wsd_pkg::MAX_FRAME_LEN_RST;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (room) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign tx.valid        = out_valid_q;
	assign tx.payload_byte = out_q.payload_byte;
	assign tx.frame_opcode = out_q.frame_opcode;
	assign tx.has_data     = out_q.has_data;
	assign tx.msg_end      = out_q.msg_end;
	assign tx.error_code   = out_q.error_code;

endmodule

[sv/wsd_checker.sv]
// ----------------------------------------------------------------------------
// wsd_checker
// port-level checks of the deframer, bound to the top level
// ----------------------------------------------------------------------------
module wsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [7:0] payload_byte,
	input logic [3:0] frame_opcode,
	input logic       has_data,
	input logic       msg_end,
	input logic [1:0] error_code
);

	// an error item carries nothing else
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && error_code != wsd_pkg::ERR_NONE) |->
		(payload_byte == 8'd0 && frame_opcode == 4'd0 && !has_data && !msg_end))
		else $error("error item with data fields set");

	// an item without data is an empty finishing frame
	a_empty_end: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && !has_data && error_code == wsd_pkg::ERR_NONE) |-> msg_end)
		else $error("empty item without msg_end");

	// an empty output stage never holds back input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!tx_valid |-> rx_ready)
		else $error("input stalled with empty output stage");

	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && !tx_ready) |=> tx_valid)
		else $error("tx valid dropped while stalled");

	a_tx_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_valid && !tx_ready) |=>
		($stable(payload_byte) && $stable(frame_opcode) && $stable(has_data)
		&& $stable(msg_end) && $stable(error_code)))
		else $error("tx item changed while stalled");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rx_valid(rx.valid),
	.rx_ready(rx.ready),
	.tx_valid(tx.valid),
	.tx_ready(tx.ready),
	.payload_byte(tx.payload_byte),
	.frame_opcode(tx.frame_opcode),
	.has_data(tx.has_data),
	.msg_end(tx.msg_end),
	.error_code(tx.error_code)
);
